// ===== rtl/a64_branch_and_move_wide_executor_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the branch and move-wide executor
// Shared property forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef A64_BRANCH_AND_MOVE_WIDE_EXECUTOR_UNIT_DEFINES_SVH
`define A64_BRANCH_AND_MOVE_WIDE_EXECUTOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define A64BMW_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("executor assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define A64BMW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("executor assertion failed");

`endif

// ===== rtl/a64bmw_pkg.sv =====
// ---------------------------------------------------------------------------
// Branch and move-wide executor package
// Operation and status codes, item and result types shared by the modules.
// ---------------------------------------------------------------------------
package a64bmw_pkg;

    typedef enum logic [2:0] {
        OP_EXIT      = 3'd0,
        OP_INTERRUPT = 3'd1,
        OP_NOP       = 3'd2,
        OP_SVC       = 3'd3,
        OP_BRK       = 3'd4,
        OP_RET       = 3'd5,
        OP_BRANCH    = 3'd6,
        OP_MOVW      = 3'd7
    } req_type_t;

    typedef enum logic [1:0] {
        ST_CONTINUE  = 2'd0,
        ST_END_BLOCK = 2'd1,
        ST_INTERRUPT = 2'd2
    } status_t;

    localparam logic [1:0] MOV_N    = 2'd0;
    localparam logic [1:0] MOV_KEEP = 2'd1;
    localparam logic [1:0] MOV_Z    = 2'd2;
    localparam logic [1:0] MOV_K    = 2'd3;

    localparam logic       CFG_SYSCALL    = 1'b0;
    localparam logic       CFG_BREAKPOINT = 1'b1;
    localparam logic [7:0] SYSCALL_RESET    = 8'd128;
    localparam logic [7:0] BREAKPOINT_RESET = 8'd3;

    localparam logic [4:0]  LINK_REG   = 5'd30;
    localparam int          NUM_REGS   = 32;
    localparam logic [63:0] INSN_BYTES = 64'd4;
    localparam logic [63:0] LANE_MASK  = 64'h0000_0000_0000_ffff;

    localparam int IN_DATA_W  = 192;
    localparam int OUT_DATA_W = 200;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [63:0] target_address;
        logic [63:0] fault_address_in;
        logic [7:0]  interrupt_code_in;
        logic [4:0]  register_index;
        logic [27:0] branch_offset;
        logic        link_flag;
        logic [1:0]  move_opcode;
        logic [1:0]  halfword_select;
        logic [15:0] immediate_value;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  interrupt_code;
        logic [63:0] next_pc;
        logic        fault_we;
        logic [63:0] fault_address;
        logic        reg_we;
        logic [4:0]  reg_index;
        logic [63:0] written_value;
    } exec_result_t;

endpackage

// ===== rtl/a64_branch_and_move_wide_executor_unit.sv =====
// ---------------------------------------------------------------------------
// AArch64 branch and move-wide executor
// Executes one predecoded operation per beat against pc, the register file
// and the fault address, and returns one result beat per input beat.
// ---------------------------------------------------------------------------
// The unit takes one input beat every clock cycle while the result register
// is empty or taken; each result passes the input register and then the
// execute stage that loads the result register.
// The register file, with the stack pointer at index 31, is held in
// flip-flops with a single read port, and pc, registers and fault address
// update as the result register loads, so back-to-back dependent beats see
// each other's writes without stalls. Only a full result register that is
// not taken holds back input.
module a64_branch_and_move_wide_executor_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: target_address[63:0], fault_address_in[127:64],
    // interrupt_code_in[135:128], register_index[140:136],
    // branch_offset[168:141], link_flag[169], move_opcode[171:170],
    // halfword_select[173:172], immediate_value[189:174], zero fill.
    input  logic [a64bmw_pkg::IN_DATA_W-1:0]    s_tdata,
    // Fields from bit 0: req_type[2:0].
    input  logic [2:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: interrupt_code_out[7:0], next_pc[71:8],
    // fault_address_out[135:72], written_value[199:136].
    output logic [a64bmw_pkg::OUT_DATA_W-1:0]   m_tdata,
    // Fields from bit 0: status[1:0].
    output logic [1:0]                          m_tuser,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_addr,
    input  logic [7:0]                          cfg_wr_data
);
    import a64bmw_pkg::*;

    logic         in_valid_reg;
    item_t        item_reg;
    logic         out_valid_reg;
    logic [1:0]   out_user_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [63:0]  pc_reg;
    logic [63:0]  fault_reg;
    logic [63:0]  regs_reg [NUM_REGS];
    logic [7:0]   syscall_reg;
    logic [7:0]   breakpoint_reg;
    logic         advance;
    item_t        item_next;
    exec_result_t result;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb begin
        item_next.req_type          = s_tuser;
        item_next.target_address    = s_tdata[63:0];
        item_next.fault_address_in  = s_tdata[127:64];
        item_next.interrupt_code_in = s_tdata[135:128];
        item_next.register_index    = s_tdata[140:136];
        item_next.branch_offset     = s_tdata[168:141];
        item_next.link_flag         = s_tdata[169];
        item_next.move_opcode       = s_tdata[171:170];
        item_next.halfword_select   = s_tdata[173:172];
        item_next.immediate_value   = s_tdata[189:174];
    end

    a64bmw_execute u_execute (
        .item            (item_reg),
        .pc              (pc_reg),
        .fault_address   (fault_reg),
        .reg_value       (regs_reg[item_reg.register_index]),
        .syscall_code    (syscall_reg),
        .breakpoint_code (breakpoint_reg),
        .result          (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_user_reg <= result.status;
            out_data_reg <= {result.written_value, result.fault_address,
                             result.next_pc, result.interrupt_code};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg    <= '0;
            fault_reg <= '0;
            for (int i = 0; i < NUM_REGS; i++) begin
                regs_reg[i] <= '0;
            end
        end else if (advance) begin
            pc_reg <= result.next_pc;
            if (result.fault_we) begin
                fault_reg <= result.fault_address;
            end
            if (result.reg_we) begin
                regs_reg[result.reg_index] <= result.written_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            syscall_reg    <= SYSCALL_RESET;
            breakpoint_reg <= BREAKPOINT_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_addr == CFG_SYSCALL) begin
                syscall_reg <= cfg_wr_data;
            end
            if (cfg_addr == CFG_BREAKPOINT) begin
                breakpoint_reg <= cfg_wr_data;
            end
        end
    end

`include "a64_branch_and_move_wide_executor_unit_defines.svh"

    `A64BMW_ASSERT_SAME(a_code_only_on_interrupt, aclk, aresetn, m_tvalid && (m_tuser != ST_INTERRUPT), m_tdata[7:0] == 8'd0)
    `A64BMW_ASSERT_SAME(a_no_write_on_interrupt, aclk, aresetn, m_tvalid && (m_tuser == ST_INTERRUPT), m_tdata[199:136] == 64'd0)
    `A64BMW_ASSERT_SAME(a_full_stall_blocks_input, aclk, aresetn, in_valid_reg && out_valid_reg && !m_tready, !s_tready)
    `A64BMW_ASSERT_NEXT(a_advance_fills_output, aclk, aresetn, advance, out_valid_reg && (pc_reg == m_tdata[71:8]))

endmodule

// ===== rtl/a64bmw_execute.sv =====
// ---------------------------------------------------------------------------
// Branch and move-wide execute logic
// Computes status, next pc, fault address and register write for one item.
// ---------------------------------------------------------------------------
module a64bmw_execute (
    input  a64bmw_pkg::item_t        item,
    input  logic [63:0]              pc,
    input  logic [63:0]              fault_address,
    input  logic [63:0]              reg_value,
    input  logic [7:0]               syscall_code,
    input  logic [7:0]               breakpoint_code,
    output a64bmw_pkg::exec_result_t result
);
    import a64bmw_pkg::*;

    logic [5:0]  shift;
    logic [63:0] placed;
    logic [63:0] lane;
    logic [63:0] move_value;
    logic [63:0] offset;
    logic [63:0] pc_plus4;

    assign shift    = {item.halfword_select, 4'd0};
    assign placed   = {48'd0, item.immediate_value} << shift;
    assign lane     = LANE_MASK << shift;
    assign offset   = {{36{item.branch_offset[27]}}, item.branch_offset};
    assign pc_plus4 = pc + INSN_BYTES;

    always_comb begin
        case (item.move_opcode)
            MOV_N:   move_value = ~placed;
            MOV_Z:   move_value = placed;
            MOV_K:   move_value = (reg_value & ~lane) | placed;
            default: move_value = reg_value;
        endcase
    end

    always_comb begin
        result                = '0;
        result.status         = ST_CONTINUE;
        result.next_pc        = pc_plus4;
        result.fault_address  = fault_address;
        result.reg_index      = item.register_index;
        case (req_type_t'(item.req_type))
            OP_EXIT: begin
                result.next_pc = item.target_address;
                result.status  = ST_END_BLOCK;
            end
            OP_INTERRUPT: begin
                result.next_pc        = item.target_address;
                result.fault_we       = 1'b1;
                result.fault_address  = item.fault_address_in;
                result.status         = ST_INTERRUPT;
                result.interrupt_code = item.interrupt_code_in;
            end
            OP_NOP: begin
                result.status = ST_CONTINUE;
            end
            OP_SVC: begin
                result.fault_we       = 1'b1;
                result.fault_address  = '0;
                result.status         = ST_INTERRUPT;
                result.interrupt_code = syscall_code;
            end
            OP_BRK: begin
                result.fault_we       = 1'b1;
                result.fault_address  = '0;
                result.status         = ST_INTERRUPT;
                result.interrupt_code = breakpoint_code;
            end
            OP_RET: begin
                result.next_pc = reg_value;
                result.status  = ST_END_BLOCK;
            end
            OP_BRANCH: begin
                result.next_pc   = pc + offset;
                result.status    = ST_END_BLOCK;
                result.reg_we    = item.link_flag;
                result.reg_index = LINK_REG;
                if (item.link_flag) begin
                    result.written_value = pc_plus4;
                end
            end
            OP_MOVW: begin
                result.reg_we        = 1'b1;
                result.written_value = move_value;
            end
            default: begin
                result.status = ST_CONTINUE;
            end
        endcase
    end

endmodule

// ===== test/a64bmw_result_checker.sv =====
// ----------------------------------------------------------------------------
// Result checker for the branch and move-wide executor
// Watches the input, result and config write ports, keeps its own copy of
// pc, the register file, the fault address and the interrupt codes, predicts
// one result per accepted input beat and compares each result beat in order.
// ----------------------------------------------------------------------------
module a64bmw_result_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [a64bmw_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [2:0]                          s_tuser,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [a64bmw_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic [1:0]                          m_tuser,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_addr,
    input  logic [7:0]                          cfg_wr_data,
    output int                                  pending_results,
    output int                                  error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import a64bmw_pkg::*;

    typedef struct packed {
        status_t     status;
        logic [7:0]  irq_code;
        logic [63:0] next_pc;
        logic [63:0] fault_addr;
        logic [63:0] written;
    } beat_result_t;

    logic [63:0]  pc_q;
    logic [63:0]  regs_q [NUM_REGS];
    logic [63:0]  fault_q;
    logic [7:0]   svc_code_q;
    logic [7:0]   brk_code_q;
    beat_result_t expected_q [$];
    int           errors = 0;

    function automatic beat_result_t execute_beat(input item_t it);
        beat_result_t r;
        req_type_t    op;
        logic [63:0]  offset;
        logic [5:0]   shift;
        logic [63:0]  placed;
        logic [63:0]  value;
        op         = req_type_t'(it.req_type);
        r.status   = ST_CONTINUE;
        r.irq_code = '0;
        r.written  = '0;
        offset     = {{36{it.branch_offset[27]}}, it.branch_offset};
        shift      = {it.halfword_select, 4'b0000};
        placed     = {48'b0, it.immediate_value} << shift;
        case (op)
            OP_EXIT: begin
                pc_q     = it.target_address;
                r.status = ST_END_BLOCK;
            end
            OP_INTERRUPT: begin
                pc_q       = it.target_address;
                fault_q    = it.fault_address_in;
                r.status   = ST_INTERRUPT;
                r.irq_code = it.interrupt_code_in;
            end
            OP_NOP: begin
                pc_q = pc_q + INSN_BYTES;
            end
            OP_SVC, OP_BRK: begin
                pc_q       = pc_q + INSN_BYTES;
                fault_q    = '0;
                r.status   = ST_INTERRUPT;
                r.irq_code = (op == OP_SVC) ? svc_code_q : brk_code_q;
            end
            OP_RET: begin
                pc_q     = regs_q[it.register_index];
                r.status = ST_END_BLOCK;
            end
            OP_BRANCH: begin
                if (it.link_flag) begin
                    r.written        = pc_q + INSN_BYTES;
                    regs_q[LINK_REG] = r.written;
                end
                pc_q     = pc_q + offset;
                r.status = ST_END_BLOCK;
            end
            default: begin
                case (it.move_opcode)
                    MOV_N:   value = ~placed;
                    MOV_Z:   value = placed;
                    MOV_K:   value = (regs_q[it.register_index] & ~(LANE_MASK << shift)) | placed;
                    default: value = regs_q[it.register_index];
                endcase
                regs_q[it.register_index] = value;
                r.written = value;
                pc_q      = pc_q + INSN_BYTES;
            end
        endcase
        r.next_pc    = pc_q;
        r.fault_addr = fault_q;
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        item_t        beat_in;
        beat_result_t actual;
        beat_result_t predicted;
        if (!aresetn) begin
            pc_q    = '0;
            fault_q = '0;
            foreach (regs_q[i]) regs_q[i] = '0;
            svc_code_q = SYSCALL_RESET;
            brk_code_q = BREAKPOINT_RESET;
            expected_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                actual.status     = status_t'(m_tuser);
                actual.irq_code   = m_tdata[7:0];
                actual.next_pc    = m_tdata[71:8];
                actual.fault_addr = m_tdata[135:72];
                actual.written    = m_tdata[199:136];
                if (expected_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("%0t: result beat with nothing expected: status %0d code %h",
                                 $realtime, actual.status, actual.irq_code);
                    end
                end else begin
                    predicted = expected_q.pop_front();
                    if (actual !== predicted) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%0t: expected status %0d code %h pc %h fault %h wr %h",
                                     $realtime, predicted.status, predicted.irq_code,
                                     predicted.next_pc, predicted.fault_addr, predicted.written);
                            $display("%0t: actual   status %0d code %h pc %h fault %h wr %h",
                                     $realtime, actual.status, actual.irq_code,
                                     actual.next_pc, actual.fault_addr, actual.written);
                        end
                    end
                end
            end
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_SYSCALL) begin
                    svc_code_q = cfg_wr_data;
                end else begin
                    brk_code_q = cfg_wr_data;
                end
            end
            if (s_tvalid && s_tready) begin
                beat_in.req_type          = s_tuser;
                beat_in.target_address    = s_tdata[63:0];
                beat_in.fault_address_in  = s_tdata[127:64];
                beat_in.interrupt_code_in = s_tdata[135:128];
                beat_in.register_index    = s_tdata[140:136];
                beat_in.branch_offset     = s_tdata[168:141];
                beat_in.link_flag         = s_tdata[169];
                beat_in.move_opcode       = s_tdata[171:170];
                beat_in.halfword_select   = s_tdata[173:172];
                beat_in.immediate_value   = s_tdata[189:174];
                expected_q.push_back(execute_beat(beat_in));
            end
        end
        pending_results <= expected_q.size();
        error_count     <= errors;
    end

endmodule

// ===== test/a64_branch_and_move_wide_executor_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the AArch64 branch and move-wide executor
// Drives directed and random operation beats with random gaps and result
// back-pressure, changes the interrupt codes between phases while the unit is
// idle, and leaves prediction and comparison to the result checker.
// ----------------------------------------------------------------------------
module a64_branch_and_move_wide_executor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import a64bmw_pkg::*;

    localparam int         RANDOM_BEATS = 950;
    localparam int         PHASES       = 4;
    localparam int         HOLD_CYCLES  = 60;
    localparam int         IDLE_PERCENT = 19;
    localparam logic [4:0] SP_REG       = 5'd31;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata     = '0;
    logic [2:0]            s_tuser     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_wr_en   = 1'b0;
    logic                  cfg_addr    = 1'b0;
    logic [7:0]            cfg_wr_data = '0;
    int                    pending_results;
    int                    error_count;
    logic                  quiet         = 1'b0;
    int                    hold_requests = 0;

    a64_branch_and_move_wide_executor_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    a64bmw_result_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wr_data     (cfg_wr_data),
        .pending_results (pending_results),
        .error_count     (error_count)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic item_t op_item(input req_type_t op);
        item_t       it;
        logic [31:0] bits;
        bits                 = $urandom;
        it.req_type          = op;
        it.target_address    = {$urandom, $urandom};
        it.fault_address_in  = {$urandom, $urandom};
        it.interrupt_code_in = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1)) begin
            it.register_index = 5'($urandom_range(0, 31));
        end else begin
            case ($urandom_range(0, 3))
                0:       it.register_index = 5'd0;
                1:       it.register_index = 5'd1;
                2:       it.register_index = LINK_REG;
                default: it.register_index = SP_REG;
            endcase
        end
        it.branch_offset   = bits[27:0];
        it.link_flag       = 1'($urandom_range(0, 1));
        it.move_opcode     = 2'($urandom_range(0, 3));
        it.halfword_select = 2'($urandom_range(0, 3));
        it.immediate_value = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    function automatic item_t random_item();
        int pick;
        pick = $urandom_range(0, 11);
        return op_item((pick > 7) ? OP_MOVW : req_type_t'(pick[2:0]));
    endfunction

    task automatic send_op(input item_t it);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.req_type;
        s_tdata  <= {2'b00, it.immediate_value, it.halfword_select, it.move_opcode,
                     it.link_flag, it.branch_offset, it.register_index,
                     it.interrupt_code_in, it.fault_address_in, it.target_address};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    task automatic write_codes(input logic [7:0] svc_code, input logic [7:0] brk_code);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_SYSCALL;
        cfg_wr_data <= svc_code;
        @(posedge aclk);
        cfg_addr    <= CFG_BREAKPOINT;
        cfg_wr_data <= brk_code;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : receiver
        int hold_left;
        int served;
        hold_left = 0;
        served    = 0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (served != hold_requests) begin
                served    = hold_requests;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    initial begin : stimulus
        item_t it;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        it = op_item(OP_EXIT);      it.target_address = '1;                         send_op(it);
        it = op_item(OP_EXIT);      it.target_address = '0;                         send_op(it);
        it = op_item(OP_INTERRUPT); it.target_address = 64'h8000_0000_0000_0000;
        it.fault_address_in = '1;   it.interrupt_code_in = 8'hff;                   send_op(it);
        it = op_item(OP_INTERRUPT); it.fault_address_in = '0;
        it.interrupt_code_in = 8'h00;                                               send_op(it);
        it = op_item(OP_NOP);                                                       send_op(it);
        it = op_item(OP_SVC);                                                       send_op(it);
        it = op_item(OP_BRK);                                                       send_op(it);
        it = op_item(OP_RET);       it.register_index = SP_REG;                     send_op(it);
        it = op_item(OP_MOVW);      it.move_opcode = MOV_N;    it.register_index = 5'd0;
        it.halfword_select = 2'd0;  it.immediate_value = 16'h0000;                  send_op(it);
        it = op_item(OP_MOVW);      it.move_opcode = MOV_K;    it.register_index = 5'd0;
        it.halfword_select = 2'd1;  it.immediate_value = 16'h1234;                  send_op(it);
        it = op_item(OP_MOVW);      it.move_opcode = MOV_K;    it.register_index = 5'd0;
        it.halfword_select = 2'd3;  it.immediate_value = 16'h0000;                  send_op(it);
        it = op_item(OP_MOVW);      it.move_opcode = MOV_KEEP; it.register_index = 5'd0;
                                                                                    send_op(it);
        it = op_item(OP_MOVW);      it.move_opcode = MOV_Z;    it.register_index = SP_REG;
        it.halfword_select = 2'd3;  it.immediate_value = 16'hffff;                  send_op(it);
        it = op_item(OP_MOVW);      it.move_opcode = MOV_N;    it.register_index = SP_REG;
        it.halfword_select = 2'd2;  it.immediate_value = 16'hffff;                  send_op(it);
        it = op_item(OP_MOVW);      it.move_opcode = MOV_K;    it.register_index = SP_REG;
        it.halfword_select = 2'd0;  it.immediate_value = 16'hffff;                  send_op(it);
        it = op_item(OP_RET);       it.register_index = 5'd0;                       send_op(it);
        it = op_item(OP_RET);       it.register_index = SP_REG;                     send_op(it);
        it = op_item(OP_BRANCH);    it.link_flag = 1'b1; it.branch_offset = 28'h7ff_ffff;
                                                                                    send_op(it);
        it = op_item(OP_BRANCH);    it.link_flag = 1'b0; it.branch_offset = 28'h800_0000;
                                                                                    send_op(it);
        it = op_item(OP_BRANCH);    it.link_flag = 1'b1; it.branch_offset = 28'hfff_fffc;
                                                                                    send_op(it);
        it = op_item(OP_RET);       it.register_index = LINK_REG;                   send_op(it);
        it = op_item(OP_MOVW);      it.move_opcode = MOV_Z;    it.register_index = LINK_REG;
        it.halfword_select = 2'd0;  it.immediate_value = 16'h0000;                  send_op(it);
        it = op_item(OP_MOVW);      it.move_opcode = MOV_KEEP; it.register_index = LINK_REG;
                                                                                    send_op(it);
        it = op_item(OP_BRANCH);    it.link_flag = 1'b0; it.branch_offset = '0;     send_op(it);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       write_codes(8'h00, 8'hff);
                1:       write_codes(8'hff, 8'h00);
                default: write_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
            quiet <= (phase == 2);
            if (phase == 1) begin
                hold_requests <= hold_requests + 1;
            end
            for (int n = 0; n < RANDOM_BEATS / PHASES; n++) begin
                send_op(random_item());
                if (phase == 3 && n == 100) begin
                    drain();
                end
            end
            drain();
        end

        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS a64_branch_and_move_wide_executor_unit");
        end else begin
            $display("FAIL a64_branch_and_move_wide_executor_unit");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("FAIL a64_branch_and_move_wide_executor_unit");
        $finish;
    end

endmodule
